>>> hw/rtl/rar_pkg.sv
package rar_pkg;

  localparam int unsigned OperandWidthDef = 16;
  localparam int unsigned ResNumW = 32;
  localparam int unsigned ResDenW = 31;

  typedef enum logic [1:0] {
    ActAdd = 2'd0,
    ActSub = 2'd1,
    ActMul = 2'd2,
    ActDiv = 2'd3
  } action_e;

endpackage

>>> hw/rtl/rar_front.sv
module rar_front import rar_pkg::*; #(
  parameter int unsigned OperandWidth = OperandWidthDef,
  parameter int unsigned ProdW = 2 * OperandWidth + 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              action_i,
  input  logic [OperandWidth-1:0] a_num_i,
  input  logic [OperandWidth-2:0] a_den_i,
  input  logic [OperandWidth-1:0] b_num_i,
  input  logic [OperandWidth-2:0] b_den_i,
  output logic                    q_valid_o,
  input  logic                    q_stall_i,
  output logic [ProdW-1:0]        q_nm_o,
  output logic [ProdW-1:0]        q_dm_o,
  output logic                    q_neg_o,
  output logic                    q_dz_o,
  output logic                    q_bad_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StMul  = 3'b010,
    StSum  = 3'b100
  } fstate_e;

  localparam int unsigned MulW = 2 * OperandWidth;

  fstate_e state_q, state_d;
  logic [1:0] act_q;
  logic signed [OperandWidth-1:0] an_q, bn_q;
  logic signed [OperandWidth:0] ad_q, bd_q;
  logic signed [MulW-1:0] p1_q, p2_q, p3_q;
  logic signed [MulW-1:0] p1_d, p2_d, p3_d;
  logic signed [ProdW-1:0] num, den;
  logic vld_q, nxt_vld;
  logic [ProdW-1:0] nm_q, dm_q;
  logic neg_q, dz_q, bad_q;

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    p1_d = MulW'(an_q) * MulW'(bd_q);
    p2_d = MulW'(bn_q) * MulW'(ad_q);
    p3_d = MulW'(ad_q) * MulW'(bd_q);
    case (act_q)
      ActMul: begin
        p1_d = MulW'(an_q) * MulW'(bn_q);
      end
      ActDiv: begin
        p3_d = MulW'(ad_q) * MulW'(bn_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    num = ProdW'(p1_q);
    den = ProdW'(p3_q);
    case (act_q)
      ActAdd: num = ProdW'(p1_q) + ProdW'(p2_q);
      ActSub: num = ProdW'(p1_q) - ProdW'(p2_q);
      default: ;
    endcase
  end

  assign nxt_vld = vld_q && q_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_valid_i) state_d = StMul;
      StMul:  state_d = StSum;
      StSum:  if (!nxt_vld) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StSum && !nxt_vld) vld_q <= 1'b1;
      else if (!q_stall_i) vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      act_q <= action_i;
      an_q  <= a_num_i;
      bn_q  <= b_num_i;
      ad_q  <= {2'b00, a_den_i};
      bd_q  <= {2'b00, b_den_i};
    end
    if (state_q == StMul) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
      p3_q <= p3_d;
    end
    if (state_q == StSum && !nxt_vld) begin
      dz_q  <= (act_q == ActDiv) && (bn_q == '0);
      bad_q <= (den == '0);
      nm_q  <= num[ProdW-1] ? ProdW'(-num) : num;
      dm_q  <= den[ProdW-1] ? ProdW'(-den) : den;
      neg_q <= num[ProdW-1] ^ den[ProdW-1];
    end
  end

  assign q_valid_o = vld_q;
  assign q_nm_o    = nm_q;
  assign q_dm_o    = dm_q;
  assign q_neg_o   = neg_q;
  assign q_dz_o    = dz_q;
  assign q_bad_o   = bad_q;

endmodule

>>> hw/rtl/rar_divu.sv
module rar_divu #(
  parameter int unsigned W = 33
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(W + 1);

  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [W-1:0]    q_q, r_q, d_q;
  logic [W:0]      trial;
  logic [W:0]      shifted;

  assign shifted = {r_q, q_q[W-1]};
  assign trial   = shifted - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(W);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == CntW'(1));
      if (cnt_q == CntW'(1)) busy_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i;
      r_q <= '0;
      d_q <= divisor_i;
    end else if (busy_q) begin
      if (!trial[W]) begin
        r_q <= trial[W-1:0];
        q_q <= {q_q[W-2:0], 1'b1};
      end else begin
        r_q <= shifted[W-1:0];
        q_q <= {q_q[W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;

endmodule

>>> hw/rtl/rar_back.sv
module rar_back import rar_pkg::*; #(
  parameter int unsigned ProdW = 33
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_stall_o,
  input  logic [ProdW-1:0]    q_nm_i,
  input  logic [ProdW-1:0]    q_dm_i,
  input  logic                q_neg_i,
  input  logic                q_dz_i,
  input  logic                q_bad_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ResNumW-1:0]  res_num_o,
  output logic [ResDenW-1:0]  res_den_o,
  output logic                div_zero_o
);

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StGcd  = 6'b000010,
    StGwt  = 6'b000100,
    StDvn  = 6'b001000,
    StDvd  = 6'b010000,
    StOut  = 6'b100000
  } bstate_e;

  bstate_e state_q, state_d;
  logic [ProdW-1:0] nm_q, dm_q, x_q, y_q, g_q;
  logic neg_q;
  logic start;
  logic [ProdW-1:0] dvd, dvs, quot, rem;
  logic done;
  logic ovld_q;
  logic [ResNumW-1:0] rn_q;
  logic [ResDenW-1:0] rd_q;
  logic dz_q;

  rar_divu #(.W(ProdW)) u_div (
    .clk_i, .rst_ni,
    .start_i(start), .dividend_i(dvd), .divisor_i(dvs),
    .done_o(done), .quot_o(quot), .rem_o(rem)
  );

  assign q_stall_o = (state_q != StIdle) || (ovld_q && out_stall_i);

  always_comb begin
    start = 1'b0;
    dvd   = x_q;
    dvs   = y_q;
    case (state_q)
      StGcd: start = (y_q != '0);
      StDvn: begin
        start = 1'b1;
        dvd   = nm_q;
        dvs   = g_q;
      end
      StDvd: begin
        start = done;
        dvd   = dm_q;
        dvs   = g_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (q_valid_i && !q_stall_o && !q_dz_i && !q_bad_i) state_d = StGcd;
      StGcd:  state_d = (y_q == '0) ? StDvn : StGwt;
      StGwt:  if (done) state_d = StGcd;
      StDvn:  state_d = StDvd;
      StDvd:  if (done) state_d = StOut;
      StOut:  if (done && !(ovld_q && out_stall_i)) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == StIdle && q_valid_i && !q_stall_o && (q_dz_i || q_bad_i)) ||
          (state_q == StOut && state_d == StIdle)) begin
        ovld_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && q_valid_i && !q_stall_o) begin
      nm_q  <= q_nm_i;
      dm_q  <= q_dm_i;
      x_q   <= q_nm_i;
      y_q   <= q_dm_i;
      neg_q <= q_neg_i;
      rn_q  <= '0;
      rd_q  <= '0;
      dz_q  <= q_dz_i;
    end
    if (state_q == StGcd && y_q == '0) g_q <= x_q;
    if (state_q == StGwt && done) begin
      x_q <= y_q;
      y_q <= rem;
    end
    if (state_q == StDvd && done) x_q <= quot;
    if (state_q == StOut && state_d == StIdle) begin
      dz_q <= 1'b0;
      if (x_q == '0) begin
        rn_q <= '0;
        rd_q <= ResDenW'(1);
      end else begin
        rn_q <= neg_q ? ResNumW'(-x_q) : ResNumW'(x_q);
        rd_q <= ResDenW'(quot);
      end
    end
  end

  assign out_valid_o = ovld_q;
  assign res_num_o   = rn_q;
  assign res_den_o   = rd_q;
  assign div_zero_o  = dz_q;

endmodule

>>> hw/rtl/rational_arith_reduce.sv
// Rational arithmetic with GCD reduction.
// Input channel: in_valid_i / in_stall_o with action_i, a_num_i, a_den_i,
// b_num_i, b_den_i. Output channel: out_valid_o / out_stall_i with
// res_num_o, res_den_o, div_zero_o. A request moves on valid high, stall low.
// The front captures the operands, registers the cross products and
// queues one classified request; the back reduces it and drives the
// output register. The Euclid remainder steps are all carried out by
// one bit-serial divider, which also divides out the GCD. A divide by
// zero or a zero denominator skips the divider.
// One request is reduced at a time; the front may hold the next one.
// Reset clears all valids; no request is in flight afterwards.
// A stalled output holds its value; the back then stops taking requests,
// the queue fills and in_stall_o rises.
module rational_arith_reduce import rar_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OperandWidthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               action_i,
  input  logic [OPERAND_WIDTH-1:0] a_num_i,
  input  logic [OPERAND_WIDTH-2:0] a_den_i,
  input  logic [OPERAND_WIDTH-1:0] b_num_i,
  input  logic [OPERAND_WIDTH-2:0] b_den_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [ResNumW-1:0]       res_num_o,
  output logic [ResDenW-1:0]       res_den_o,
  output logic                     div_zero_o
);

  localparam int unsigned ProdW = 2 * OPERAND_WIDTH + 1;

  logic             q_valid, q_stall, q_neg, q_dz, q_bad;
  logic [ProdW-1:0] q_nm, q_dm;

  rar_front #(.OperandWidth(OPERAND_WIDTH), .ProdW(ProdW)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .action_i, .a_num_i, .a_den_i, .b_num_i, .b_den_i,
    .q_valid_o(q_valid), .q_stall_i(q_stall),
    .q_nm_o(q_nm), .q_dm_o(q_dm), .q_neg_o(q_neg), .q_dz_o(q_dz), .q_bad_o(q_bad)
  );

  rar_back #(.ProdW(ProdW)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_stall_o(q_stall),
    .q_nm_i(q_nm), .q_dm_i(q_dm), .q_neg_i(q_neg), .q_dz_i(q_dz), .q_bad_i(q_bad),
    .out_valid_o, .out_stall_i, .res_num_o, .res_den_o, .div_zero_o
  );

endmodule

>>> dv/tb_rational_arith_reduce.sv
module tb_rational_arith_reduce;
  import rar_pkg::*;

  localparam int unsigned OpW = 16;
  localparam int unsigned IdleLimit = 20000;

  typedef struct {
    action_e        act;
    logic [OpW-1:0] an;
    logic [OpW-2:0] ad;
    logic [OpW-1:0] bn;
    logic [OpW-2:0] bd;
  } rat_req_t;

  typedef struct {
    logic [ResNumW-1:0] num;
    logic [ResDenW-1:0] den;
    logic               dz;
  } rat_res_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic [1:0] action_i;
  logic [OpW-1:0] a_num_i;
  logic [OpW-2:0] a_den_i;
  logic [OpW-1:0] b_num_i;
  logic [OpW-2:0] b_den_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [ResNumW-1:0] res_num_o;
  logic [ResDenW-1:0] res_den_o;
  logic div_zero_o;

  rat_req_t pending_q[$];
  rat_res_t reduced_q[$];
  bit failed;
  bit quiet;
  int unsigned send_gap;
  int unsigned stall_len;
  int unsigned idle_cycles;

  rational_arith_reduce #(.OPERAND_WIDTH(OpW)) dut (.*);

  function automatic rat_res_t reduce_rational(rat_req_t r);
    longint an, ad, bn, bd, num, den;
    longint unsigned nm, dm, x, y, t;
    rat_res_t res;
    an = longint'($signed(r.an));
    bn = longint'($signed(r.bn));
    ad = longint'({1'b0, r.ad});
    bd = longint'({1'b0, r.bd});
    res = '{num: '0, den: '0, dz: 1'b0};
    if (r.act == ActDiv && bn == 0) begin
      res.dz = 1'b1;
      return res;
    end
    case (r.act)
      ActAdd: begin num = an * bd + bn * ad; den = ad * bd; end
      ActSub: begin num = an * bd - bn * ad; den = ad * bd; end
      ActMul: begin num = an * bn; den = ad * bd; end
      default: begin num = an * bd; den = ad * bn; end
    endcase
    if (den == 0) return res;
    nm = (num < 0) ? longint'(-num) : longint'(num);
    dm = (den < 0) ? longint'(-den) : longint'(den);
    x = nm;
    y = dm;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    nm = nm / x;
    dm = dm / x;
    res.num = ((num < 0) != (den < 0)) ? ResNumW'(-nm) : ResNumW'(nm);
    res.den = (nm == 0) ? ResDenW'(1) : ResDenW'(dm);
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (quiet || p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [OpW-1:0] pick_num();
    case ($urandom_range(0, 3))
      0: return OpW'($signed($urandom_range(0, 40)) - 20);
      1: return OpW'($urandom_range(0, 255) * ($urandom_range(0, 1) ? 1 : -1));
      2: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, {(OpW-1){$urandom_range(0, 1) == 1}}};
      default: return OpW'($urandom);
    endcase
  endfunction

  function automatic logic [OpW-2:0] pick_den();
    case ($urandom_range(0, 3))
      0: return (OpW-1)'($urandom_range(1, 12));
      1: return (OpW-1)'($urandom_range(1, 255));
      2: return (OpW-1)'($urandom_range(1, 1 << (OpW-1)) - 1) | 1'b1;
      default: return (OpW-1)'($urandom_range(1, (1 << (OpW-1)) - 1));
    endcase
  endfunction

  task automatic add_req(action_e act, int an, int ad, int bn, int bd);
    pending_q.push_back('{act, OpW'(an), (OpW-1)'(ad), OpW'(bn), (OpW-1)'(bd)});
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      action_i <= ActAdd;
      a_num_i <= '0;
      a_den_i <= '1;
      b_num_i <= '0;
      b_den_i <= '1;
      send_gap <= 0;
    end else if (in_valid_i && in_stall_o) begin
      in_valid_i <= 1'b1;
    end else begin
      if (in_valid_i) begin
        reduced_q.push_back(reduce_rational('{action_e'(action_i), a_num_i, a_den_i,
                                              b_num_i, b_den_i}));
      end
      if (send_gap != 0) begin
        in_valid_i <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_q.size() != 0) begin
        rat_req_t r;
        r = pending_q.pop_front();
        in_valid_i <= 1'b1;
        action_i <= r.act;
        a_num_i <= r.an;
        a_den_i <= r.ad;
        b_num_i <= r.bn;
        b_den_i <= r.bd;
        send_gap <= pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_len <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (reduced_q.size() == 0) begin
          $display("%0t: unexpected result num=%0d den=%0d dz=%0b", $time,
                   $signed(res_num_o), res_den_o, div_zero_o);
          failed = 1'b1;
        end else begin
          rat_res_t e;
          e = reduced_q.pop_front();
          if (res_num_o !== e.num) begin
            $display("%0t: res_num expected %0d actual %0d", $time, $signed(e.num),
                     $signed(res_num_o));
            failed = 1'b1;
          end
          if (res_den_o !== e.den) begin
            $display("%0t: res_den expected %0d actual %0d", $time, e.den, res_den_o);
            failed = 1'b1;
          end
          if (div_zero_o !== e.dz) begin
            $display("%0t: div_zero expected %0b actual %0b", $time, e.dz, div_zero_o);
            failed = 1'b1;
          end
        end
      end
      if (stall_len != 0) begin
        out_stall_i <= 1'b1;
        stall_len <= stall_len - 1;
      end else begin
        out_stall_i <= 1'b0;
        stall_len <= pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    forever begin
      repeat ($urandom_range(100, 600)) @(posedge clk_i);
      quiet = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    failed = 1'b0;
    quiet = 1'b0;
    idle_cycles = 0;
    rst_ni = 1'b0;
    add_req(ActAdd, -32768, 1, 32767, 32767);
    add_req(ActAdd, 32767, 32767, 32767, 32767);
    add_req(ActSub, 5, 7, 5, 7);
    add_req(ActSub, -32768, 32767, 32767, 1);
    add_req(ActMul, -32768, 1, -32768, 1);
    add_req(ActMul, 0, 3, -9, 4);
    add_req(ActMul, 32767, 1, -32768, 32767);
    add_req(ActDiv, 3, 4, 0, 5);
    add_req(ActDiv, -32768, 1, -1, 32767);
    add_req(ActDiv, 7, 9, -14, 3);
    add_req(ActDiv, 0, 1, 5, 1);
    add_req(ActAdd, 3, 0, 4, 5);
    add_req(ActSub, 3, 5, 4, 0);
    add_req(ActMul, 1, 0, 1, 0);
    add_req(ActDiv, 3, 0, 2, 9);
    add_req(ActDiv, 4, 5, 2, 0);
    add_req(ActAdd, 6, 4, 10, 8);
    add_req(ActMul, 12, 18, 30, 45);
    add_req(ActSub, 0, 1, 0, 1);
    for (int i = 0; i < 700; i++) begin
      add_req(action_e'($urandom_range(0, 3)), int'($signed(pick_num())), pick_den(),
              int'($signed(pick_num())), pick_den());
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (pending_q.size() != 0 || in_valid_i || reduced_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (!failed) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
